// ===== rtl/core/frgf_pkg.sv =====
`timescale 1ns / 1ps

package frgf_pkg;

  localparam int FLOW_W        = 16;
  localparam int ID_W          = 17;
  localparam int FILL_ID_W     = 16;
  localparam int SPAN_W        = 11;
  localparam int DEF_MAX_WIDTH = 2048;

  // Object id codes that are not real objects.
  localparam logic [ID_W-1:0] ID_NO_FLOW    = 17'h1FFFF;
  localparam logic [ID_W-1:0] ID_BACKGROUND = 17'h0FFFF;

  typedef struct packed {
    logic signed [FLOW_W-1:0] flow_u;
    logic signed [FLOW_W-1:0] flow_v;
    logic signed [ID_W-1:0]   object_id;
    logic                     end_of_row;
  } pixel_t;

endpackage

// ===== rtl/core/frgf_ifs.sv =====
`timescale 1ns / 1ps

interface frgf_pixel_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [frgf_pkg::FLOW_W-1:0]     flow_u;
  logic signed [frgf_pkg::FLOW_W-1:0]     flow_v;
  logic signed [frgf_pkg::ID_W-1:0]       object_id;
  logic                                   end_of_row;

  modport source (output valid, flow_u, flow_v, object_id, end_of_row, input ready);
  modport sink   (input valid, flow_u, flow_v, object_id, end_of_row, output ready);
endinterface

interface frgf_span_if;
  logic                                   valid;
  logic                                   ready;
  logic        [frgf_pkg::SPAN_W-1:0]     span_first;
  logic        [frgf_pkg::SPAN_W-1:0]     span_last;
  logic signed [frgf_pkg::FLOW_W-1:0]     fill_u;
  logic signed [frgf_pkg::FLOW_W-1:0]     fill_v;
  logic        [frgf_pkg::FILL_ID_W-1:0]  fill_id;

  modport source (output valid, span_first, span_last, fill_u, fill_v, fill_id, input ready);
  modport sink   (input valid, span_first, span_last, fill_u, fill_v, fill_id, output ready);
endinterface

// ===== rtl/core/frgf_in_stage.sv =====
`timescale 1ns / 1ps

module frgf_in_stage (
  input  logic             clk,
  input  logic             rst,
  frgf_pixel_if.sink       pixel,
  input  logic             take,
  output logic             pix_valid,
  output frgf_pkg::pixel_t pix
);
  import frgf_pkg::*;

  // The register may be refilled in the same cycle that its beat moves on.
  assign pixel.ready = !pix_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (pixel.valid && pixel.ready) begin
      pix_valid <= 1'b1;
    end else if (take) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      pix.flow_u     <= pixel.flow_u;
      pix.flow_v     <= pixel.flow_v;
      pix.object_id  <= pixel.object_id;
      pix.end_of_row <= pixel.end_of_row;
    end
  end

endmodule

// ===== rtl/core/frgf_span_core.sv =====
`timescale 1ns / 1ps

module frgf_span_core #(
  parameter int MAX_WIDTH = frgf_pkg::DEF_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_valid,
  input  frgf_pkg::pixel_t pix,
  output logic             take,
  frgf_span_if.source      fill
);
  import frgf_pkg::*;

  localparam int               COL_W   = $clog2(MAX_WIDTH);
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_WIDTH - 1);
  localparam logic [COL_W-1:0] COL_ONE = COL_W'(1);

  logic [COL_W-1:0]          column;
  logic [COL_W-1:0]          column_next;
  logic [COL_W-1:0]          run_length;
  logic [COL_W-1:0]          run_length_next;
  logic                      left_is_valid;
  logic                      left_is_valid_next;
  logic signed [FLOW_W-1:0]  left_u;
  logic signed [FLOW_W-1:0]  left_v;
  logic [FILL_ID_W-1:0]      left_id;

  logic no_flow;
  logic backgnd;
  logic is_valid;
  logic emit;
  logic row_end;
  logic out_valid;

  assign take     = pix_valid && (!out_valid || fill.ready);
  assign no_flow  = (pix.object_id == ID_NO_FLOW);
  assign backgnd  = (pix.object_id == ID_BACKGROUND);
  assign is_valid = !no_flow && !backgnd;
  assign emit     = is_valid && (run_length != '0) && left_is_valid;
  assign row_end  = pix.end_of_row || (column == COL_MAX);

  always_comb begin
    run_length_next    = run_length;
    left_is_valid_next = left_is_valid;
    column_next        = column + COL_ONE;
    if (no_flow) begin
      run_length_next = run_length + COL_ONE;
    end else if (backgnd) begin
      run_length_next    = '0;
      left_is_valid_next = 1'b0;
    end else begin
      run_length_next    = '0;
      left_is_valid_next = 1'b1;
    end
    // A run still open at the end of a row has no right neighbour and is dropped.
    if (row_end) begin
      column_next        = '0;
      run_length_next    = '0;
      left_is_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= '0;
      run_length    <= '0;
      left_is_valid <= 1'b0;
    end else if (take) begin
      column        <= column_next;
      run_length    <= run_length_next;
      left_is_valid <= left_is_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_valid) begin
      left_u  <= pix.flow_u;
      left_v  <= pix.flow_v;
      left_id <= pix.object_id[FILL_ID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit;
    end else if (fill.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      fill.span_first <= SPAN_W'(column - run_length);
      fill.span_last  <= SPAN_W'(column - COL_ONE);
      fill.fill_u     <= (left_u <= pix.flow_u) ? left_u : pix.flow_u;
      fill.fill_v     <= (left_v <= pix.flow_v) ? left_v : pix.flow_v;
      fill.fill_id    <= left_id;
    end
  end

  assign fill.valid = out_valid;

endmodule

// ===== rtl/core/flow_row_gap_fill_unit.sv =====
`timescale 1ns / 1ps

// Row gap filler for an optical-flow image.
// The pixel channel takes flow pixels in raster order: flow_u, flow_v, object_id and
// end_of_row. An id of all ones means no flow, 65535 means background. The fill channel
// gives one span command when a run of no-flow pixels lies between two valid pixels of
// the same row: the columns to overwrite, the lesser u and v of the two neighbours and
// the id of the left one. Pixels that close no such run give no beat on the fill side.
// A pixel accepted on the pixel channel passes the pixel register, then the result register,
// before its command shows on the fill channel. One pixel is taken every cycle while the
// fill channel does not stall; the state update is a single compare and counter step
// between the two registers. A row ends at a pixel marked end_of_row, or at column
// MAX_WIDTH-1 in any case. Synchronous reset returns the column and run counters to zero
// and empties both registers. When the receiver stalls, the command holds in the result
// register while one more pixel waits in the pixel register; after that pixel ready
// falls until the command is taken.
module flow_row_gap_fill_unit #(
  parameter int MAX_WIDTH = frgf_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  frgf_pixel_if.sink  pixel,
  frgf_span_if.source fill
);
  import frgf_pkg::*;

  logic   take;
  logic   pix_valid;
  pixel_t pix;

  frgf_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .take      (take),
    .pix_valid (pix_valid),
    .pix       (pix)
  );

  frgf_span_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_span_core (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix       (pix),
    .take      (take),
    .fill      (fill)
  );

endmodule

// ===== rtl/core/frgf_checker.sv =====
`timescale 1ns / 1ps

module frgf_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  fill_valid,
  input logic                                  fill_ready,
  input logic        [frgf_pkg::SPAN_W-1:0]    span_first,
  input logic        [frgf_pkg::SPAN_W-1:0]    span_last,
  input logic signed [frgf_pkg::FLOW_W-1:0]    fill_u,
  input logic signed [frgf_pkg::FLOW_W-1:0]    fill_v,
  input logic        [frgf_pkg::FILL_ID_W-1:0] fill_id
);
  import frgf_pkg::*;

  // A stalled command must not change under the receiver.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    fill_valid && !fill_ready |=> fill_valid && $stable(span_first) && $stable(span_last)
      && $stable(fill_u) && $stable(fill_v) && $stable(fill_id))
    else $error("fill beat changed while stalled");

  // A span always runs left to right.
  a_order: assert property (@(posedge clk) disable iff (rst)
    fill_valid |-> span_first <= span_last)
    else $error("span_first beyond span_last");

  // The left neighbour is a real object, never background.
  a_id: assert property (@(posedge clk) disable iff (rst)
    fill_valid |-> fill_id != ID_BACKGROUND[FILL_ID_W-1:0])
    else $error("fill_id carries the background code");

  // Reset leaves no command pending.
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !fill_valid)
    else $error("fill beat valid straight after reset");

endmodule

bind flow_row_gap_fill_unit frgf_checker u_frgf_checker (
  .clk        (clk),
  .rst        (rst),
  .fill_valid (fill.valid),
  .fill_ready (fill.ready),
  .span_first (fill.span_first),
  .span_last  (fill.span_last),
  .fill_u     (fill.fill_u),
  .fill_v     (fill.fill_v),
  .fill_id    (fill.fill_id)
);
